/* src/blr_pkg.sv */
`default_nettype none
package blr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int WET_W      = 16;
  localparam int BEAT_W     = 20;
  localparam int WEIGHT_W   = 17;

  localparam logic [WEIGHT_W-1:0] WET_ONE = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAT_SELECT = 2'd0,
    CFG_WET_MIX     = 2'd1,
    CFG_BEAT_LENGTH = 2'd2
  } cfg_idx_t;

  // loop source for one transaction: recording, and read address equals write address
  typedef struct packed {
    logic active;
    logic hit;
  } tap_ctl_t;

endpackage
`default_nettype wire

/* src/blr_in_if.sv */
`default_nettype none
interface blr_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          loop_active;

  modport source (output valid, output sample_in, output loop_active, input ready);
  modport sink   (input valid, input sample_in, input loop_active, output ready);
endinterface
`default_nettype wire

/* src/blr_out_if.sv */
`default_nettype none
interface blr_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

/* src/blr_ram.sv */
`default_nettype none
module blr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/blr_ctrl.sv */
`default_nettype none
module blr_ctrl #(
  parameter int STORE_DEPTH = 524288
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [blr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               accept,
  input  wire logic                               loop_active,
  output logic                                    wr_en,
  output logic      [$clog2(STORE_DEPTH)-1:0]     wr_addr,
  output logic                                    rd_en,
  output logic      [$clog2(STORE_DEPTH)-1:0]     rd_addr,
  output blr_pkg::tap_ctl_t                       ctl
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = $clog2(STORE_DEPTH + 1);
  localparam int CW = LW + 1;
  localparam int MW = (blr_pkg::BEAT_W > CW) ? blr_pkg::BEAT_W : CW;
  localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

  logic                        beat_select;
  logic [blr_pkg::BEAT_W-1:0]  beat_length;
  logic [AW-1:0]               wp, fh, hh;
  logic [AW-1:0]               wp_next, fh_next, hh_next;
  logic [MW-1:0]               beat_ext, len_m;
  logic [LW-1:0]               len, half;
  logic [CW-1:0]               fh_inc, hh_inc;

  always_comb begin
    beat_ext = MW'(beat_length);
    len_m    = (beat_ext > MW'(STORE_DEPTH)) ? MW'(STORE_DEPTH) : beat_ext;
    len      = LW'(len_m);
    half     = len >> 1;
    fh_inc   = CW'(fh) + CW'(1);
    hh_inc   = CW'(hh) + CW'(1);
    if (loop_active) begin
      wp_next = (wp == LAST) ? wp : wp + AW'(1);
      fh_next = (fh_inc < CW'(len))  ? AW'(fh_inc) : '0;
      hh_next = (hh_inc < CW'(half)) ? AW'(hh_inc) : '0;
    end else begin
      wp_next = '0;
      fh_next = '0;
      hh_next = '0;
    end
  end

  assign wr_en      = accept && loop_active;
  assign wr_addr    = wp;
  assign rd_en      = accept;
  assign rd_addr    = beat_select ? fh : hh;
  assign ctl.active = loop_active;
  assign ctl.hit    = (rd_addr == wp);

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_select <= 1'b0;
      beat_length <= '0;
      wp          <= '0;
      fh          <= '0;
      hh          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          blr_pkg::CFG_BEAT_SELECT: beat_select <= cfg_data[0];
          blr_pkg::CFG_BEAT_LENGTH: beat_length <= cfg_data[blr_pkg::BEAT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        wp <= wp_next;
        fh <= fh_next;
        hh <= hh_next;
      end
    end
  end

endmodule
`default_nettype wire

/* src/blr_mix.sv */
`default_nettype none
module blr_mix #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [blr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]      dry_in,
  input  wire blr_pkg::tap_ctl_t                  ctl_in,
  input  wire logic        [SAMPLE_BITS-1:0]      rdata,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]           out_data
);

  localparam int PW = SAMPLE_BITS + blr_pkg::WEIGHT_W + 1;

  logic [blr_pkg::WEIGHT_W-1:0]   wet_q, dry_w;
  logic                           s1_v, s2_v;
  logic signed [SAMPLE_BITS-1:0]  s1_dry, loop_smp;
  blr_pkg::tap_ctl_t              s1_ctl;
  logic signed [PW-1:0]           p_dry, p_loop;
  logic signed [PW:0]             sum;
  logic                           s2_ready, o_ready;

  assign o_ready  = !out_valid || out_ready;
  assign s2_ready = !s2_v || o_ready;
  assign in_ready = !s1_v || s2_ready;

  assign dry_w    = blr_pkg::WET_ONE - wet_q;
  // a hit means the sample just written is the one read back
  assign loop_smp = (s1_ctl.active && !s1_ctl.hit) ? $signed(rdata) : s1_dry;
  assign sum      = {p_dry[PW-1], p_dry} + {p_loop[PW-1], p_loop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_q     <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == blr_pkg::CFG_WET_MIX) begin
        wet_q <= ({1'b0, cfg_data[blr_pkg::WET_W-1:0]} > blr_pkg::WET_ONE) ?
                 blr_pkg::WET_ONE : {1'b0, cfg_data[blr_pkg::WET_W-1:0]};
      end
      if (in_ready) begin
        s1_v <= in_valid;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
      if (o_ready) begin
        out_valid <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_dry <= dry_in;
      s1_ctl <= ctl_in;
    end
    if (s2_ready && s1_v) begin
      p_dry  <= $signed({1'b0, dry_w}) * s1_dry;
      p_loop <= $signed({1'b0, wet_q}) * loop_smp;
    end
    if (o_ready && s2_v) begin
      out_data <= sum[SAMPLE_BITS+14:15];
    end
  end

endmodule
`default_nettype wire

/* src/beat_repeat_looper.sv */
// channel | dir | payload                         | handshake
// rx      | in  | sample_in, loop_active          | valid/ready
// tx      | out | sample_out                      | valid/ready
// cfg     | in  | cfg_idx, cfg_data               | cfg_we, no back-pressure
//
// One transaction per clock while tx is ready; tx valid follows the rx accept through three registered stages:
// store read (one write port, one read port, registered read), multiply, sum.
// rst is synchronous: clears positions, settings and pipeline valids.
// The sample store is not cleared; only written entries are ever replayed.
// With tx held off, rx keeps moving until all three stages hold a transaction.
`default_nettype none
module beat_repeat_looper #(
  parameter int STORE_DEPTH = 524288,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [blr_pkg::CFG_DATA_W-1:0] cfg_data,
  blr_in_if.sink                              rx,
  blr_out_if.source                           tx
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic                   accept;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] rdata;
  blr_pkg::tap_ctl_t      ctl;

  assign accept = rx.valid && rx.ready;

  blr_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .loop_active(rx.loop_active),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .ctl        (ctl)
  );

  blr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(rx.sample_in),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  blr_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .dry_in   (rx.sample_in),
    .ctl_in   (ctl),
    .rdata    (rdata),
    .out_valid(tx.valid),
    .out_ready(tx.ready),
    .out_data (tx.sample_out)
  );

endmodule
`default_nettype wire

/* src/blr_checker.sv */
`default_nettype none
module blr_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_data
);

  logic [2:0] inflight;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("tx transaction changed while stalled");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd3)
    else $error("more transactions in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 3'd0)
    else $error("tx valid with no transaction in flight");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    inflight == 3'd0 |=> !out_valid)
    else $error("tx result faster than pipeline latency");

endmodule

bind beat_repeat_looper blr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_blr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (rx.valid),
  .in_ready (rx.ready),
  .out_valid(tx.valid),
  .out_ready(tx.ready),
  .out_data (tx.sample_out)
);
`default_nettype wire
